// ----- rtl/core/rcpa_pkg.sv -----
// rcpa_pkg: shared types and constants for the refcounted page allocator
// no dependencies; imported by every module under rtl/core
package rcpa_pkg;

    localparam int unsigned PAGE_SHIFT = 12;
    localparam int unsigned ADDR_W     = 32;
    localparam int unsigned OUT_CNT_W  = 16;
    localparam int unsigned CFG_IDX_W  = 1;

    // defaults for the top-level parameters
    localparam int unsigned    DEF_NUM_PAGES    = 32768;
    localparam logic [31:0]    DEF_BASE_ADDRESS = 32'h8000_0000;
    localparam int unsigned    DEF_COUNT_WIDTH  = 16;

    // register reset values
    localparam logic [31:0] KERNEL_END_RESET = 32'h8000_0000;
    localparam logic [31:0] TOP_ADDR_RESET   = 32'h8800_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KERNEL_END = 1'd0,
        REG_TOP_ADDR   = 1'd1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        OP_ALLOC  = 3'd0,
        OP_FREE   = 3'd1,
        OP_QUERY  = 3'd2,
        OP_ADDREF = 3'd3,
        OP_DONATE = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_OOM   = 3'd1,
        ST_BAD   = 3'd2,
        ST_FREE  = 3'd3,
        ST_DIRTY = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_POP,
        S_EXEC
    } state_t;

    // address check results
    typedef struct packed {
        logic in_range;  // page lies inside managed memory
        logic free_ok;   // also aligned and inside the freeable window
    } chk_t;

endpackage

// ----- rtl/core/refcounted_page_allocator.sv -----
// refcounted_page_allocator: lifo free list of pages plus per-page reference counts
// the result register is loaded from S_EXEC; an allocate passes through S_POP first (stack read)
// one word in flight: the next is taken only once the count ram read-modify-write is done,
//   and the execute step waits, input stalled, while a finished result is still held
// reset: a clearing pass zeroes all NUM_PAGES count entries, one per cycle,
//   before the first input word is taken; config writes are taken throughout
module refcounted_page_allocator
    import rcpa_pkg::*;
#(
    parameter int unsigned NUM_PAGES    = DEF_NUM_PAGES,
    parameter logic [31:0] BASE_ADDRESS = DEF_BASE_ADDRESS,
    parameter int unsigned COUNT_WIDTH  = DEF_COUNT_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    // configuration write port
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,

    // input words
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [2:0]           operation,
    input  logic [ADDR_W-1:0]    page_address,

    // result words
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [ADDR_W-1:0]    result_address,
    output logic [OUT_CNT_W-1:0] ref_count,
    output logic [2:0]           status
);

    localparam int unsigned IDX_W = $clog2(NUM_PAGES);
    localparam int unsigned TOP_W = $clog2(NUM_PAGES + 1);

    // control state
    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [TOP_W-1:0]     top_reg, top_next;          // number of stacked pages
    logic                 out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]    kend_reg;
    logic [ADDR_W-1:0]    topaddr_reg;

    // payload of the word in flight
    op_t                  op_reg, op_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    chk_t                 chk_reg, chk_next;
    logic                 oom_reg, oom_next;

    // result register
    logic [ADDR_W-1:0]    result_address_reg, result_address_next;
    logic [OUT_CNT_W-1:0] ref_count_reg, ref_count_next;
    logic [2:0]           status_reg, status_next;

    // memory ports
    logic                   cnt_we;
    logic [IDX_W-1:0]       cnt_waddr;
    logic [COUNT_WIDTH-1:0] cnt_wdata;
    logic [IDX_W-1:0]       cnt_raddr;
    logic [COUNT_WIDTH-1:0] cnt_rdata;
    logic                   stk_we;
    logic [IDX_W-1:0]       stk_waddr;
    logic [IDX_W-1:0]       stk_raddr;
    logic [IDX_W-1:0]       stk_rdata;

    // address decode of the incoming word
    logic [IDX_W-1:0]     chk_idx;
    chk_t                 chk;

    // execute-step helpers
    status_t                exec_status;
    logic [COUNT_WIDTH-1:0] exec_count;
    logic [ADDR_W-1:0]      exec_addr;
    logic [COUNT_WIDTH-1:0] rel_count;
    logic [31:0]            count_ext;

    rcpa_addr_chk #(
        .NUM_PAGES    (NUM_PAGES),
        .BASE_ADDRESS (BASE_ADDRESS)
    ) u_addr_chk (
        .addr       (page_address),
        .kernel_end (kend_reg),
        .top_addr   (topaddr_reg),
        .idx        (chk_idx),
        .chk        (chk)
    );

    // per-page reference counts
    rcpa_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NUM_PAGES)
    ) u_count_ram (
        .clk     (clk),
        .wr_en   (cnt_we),
        .wr_addr (cnt_waddr),
        .wr_data (cnt_wdata),
        .rd_addr (cnt_raddr),
        .rd_data (cnt_rdata)
    );

    // free-page stack; only entries below the top are ever used
    rcpa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (NUM_PAGES)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (stk_we),
        .wr_addr (stk_waddr),
        .wr_data (idx_reg),
        .rd_addr (stk_raddr),
        .rd_data (stk_rdata)
    );

    // the stack is always read at the top entry, so a pop has its data in S_POP
    assign stk_raddr = IDX_W'(top_reg - TOP_W'(1));
    assign stk_waddr = IDX_W'(top_reg);

    // only one word in flight; an accepted word is done when it reaches the result register
    assign in_stall = (state_reg != S_IDLE);

    assign out_valid      = out_valid_reg;
    assign result_address = result_address_reg;
    assign ref_count      = ref_count_reg;
    assign status         = status_reg;

    // count after a free: zero when the last reference goes, else one less
    assign rel_count = cnt_rdata - COUNT_WIDTH'(1);
    assign count_ext = 32'(exec_count);

    always_comb
    begin
        state_next          = state_reg;
        clr_cnt_next        = clr_cnt_reg;
        top_next            = top_reg;
        out_valid_next      = out_valid_reg && out_stall;
        op_next             = op_reg;
        idx_next            = idx_reg;
        chk_next            = chk_reg;
        oom_next            = oom_reg;
        result_address_next = result_address_reg;
        ref_count_next      = ref_count_reg;
        status_next         = status_reg;

        cnt_we      = 1'b0;
        cnt_waddr   = idx_reg;
        cnt_wdata   = '0;
        cnt_raddr   = idx_reg;
        stk_we      = 1'b0;
        exec_status = ST_OK;
        exec_count  = '0;
        exec_addr   = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                // zero one count entry per cycle
                cnt_we       = 1'b1;
                cnt_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + IDX_W'(1);
                if (clr_cnt_reg == IDX_W'(NUM_PAGES - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                cnt_raddr = chk_idx;
                if (in_valid)
                begin
                    op_next  = op_t'(operation);
                    idx_next = chk_idx;
                    chk_next = chk;
                    oom_next = (top_reg == '0);
                    if ((op_t'(operation) == OP_ALLOC) && (top_reg != '0))
                    begin
                        state_next = S_POP;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end

            S_POP:
            begin
                // popped page index is here; fetch its count
                cnt_raddr = stk_rdata;
                idx_next  = stk_rdata;
                state_next = S_EXEC;
            end

            S_EXEC:
            begin
                // hold the count read stable while the result register is busy
                if (!out_valid_reg || !out_stall)
                begin
                    unique case (op_reg)
                        OP_ALLOC:
                        begin
                            if (oom_reg)
                            begin
                                exec_status = ST_OOM;
                            end
                            else
                            begin
                                exec_status = (cnt_rdata != '0) ? ST_DIRTY : ST_OK;
                                exec_count  = COUNT_WIDTH'(1);
                                exec_addr   = BASE_ADDRESS + (ADDR_W'(idx_reg) << PAGE_SHIFT);
                                cnt_we      = 1'b1;
                                cnt_wdata   = COUNT_WIDTH'(1);
                                top_next    = top_reg - TOP_W'(1);
                            end
                        end

                        OP_FREE,
                        OP_DONATE:
                        begin
                            if (!chk_reg.free_ok)
                            begin
                                exec_status = ST_BAD;
                            end
                            else if ((op_reg == OP_DONATE) || (cnt_rdata == COUNT_WIDTH'(1)))
                            begin
                                // last reference: back on the stack unless it is full
                                cnt_we    = 1'b1;
                                cnt_wdata = '0;
                                if (top_reg < TOP_W'(NUM_PAGES))
                                begin
                                    stk_we   = 1'b1;
                                    top_next = top_reg + TOP_W'(1);
                                end
                            end
                            else if (cnt_rdata == '0)
                            begin
                                exec_status = ST_FREE;
                            end
                            else
                            begin
                                cnt_we     = 1'b1;
                                cnt_wdata  = rel_count;
                                exec_count = rel_count;
                            end
                        end

                        OP_QUERY,
                        OP_ADDREF:
                        begin
                            if (!chk_reg.in_range)
                            begin
                                exec_status = ST_BAD;
                            end
                            else if ((op_reg == OP_ADDREF) && (cnt_rdata != '1))
                            begin
                                cnt_we     = 1'b1;
                                cnt_wdata  = cnt_rdata + COUNT_WIDTH'(1);
                                exec_count = cnt_rdata + COUNT_WIDTH'(1);
                            end
                            else
                            begin
                                // query, or a saturated count
                                exec_count = cnt_rdata;
                            end
                        end

                        default:
                        begin
                            // unused codes: all-zero result, nothing changes
                            exec_status = ST_OK;
                        end
                    endcase

                    result_address_next = exec_addr;
                    ref_count_next      = count_ext[OUT_CNT_W-1:0];
                    status_next         = exec_status;
                    out_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            top_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            top_reg       <= top_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kend_reg    <= KERNEL_END_RESET;
            topaddr_reg <= TOP_ADDR_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_KERNEL_END: kend_reg    <= cfg_data;
                REG_TOP_ADDR:   topaddr_reg <= cfg_data;
            endcase
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        op_reg             <= op_next;
        idx_reg            <= idx_next;
        chk_reg            <= chk_next;
        oom_reg            <= oom_next;
        result_address_reg <= result_address_next;
        ref_count_reg      <= ref_count_next;
        status_reg         <= status_next;
    end

endmodule

// ----- rtl/core/rcpa_ram.sv -----
// rcpa_ram: simple dual-port synchronous ram, one write and one read port
// read data registered; uses rcpa_pkg
module rcpa_ram
    import rcpa_pkg::*;
#(
    parameter int unsigned WIDTH = DEF_COUNT_WIDTH,
    parameter int unsigned DEPTH = DEF_NUM_PAGES,
    localparam int unsigned AW   = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- rtl/core/rcpa_addr_chk.sv -----
// rcpa_addr_chk: decodes a physical address into a page index and range flags
// combinational; uses rcpa_pkg
module rcpa_addr_chk
    import rcpa_pkg::*;
#(
    parameter int unsigned NUM_PAGES    = DEF_NUM_PAGES,
    parameter logic [31:0] BASE_ADDRESS = DEF_BASE_ADDRESS,
    localparam int unsigned IDX_W       = $clog2(NUM_PAGES)
)
(
    input  logic [ADDR_W-1:0] addr,
    input  logic [ADDR_W-1:0] kernel_end,
    input  logic [ADDR_W-1:0] top_addr,
    output logic [IDX_W-1:0]  idx,
    output chk_t              chk
);

    localparam int unsigned PN_W = ADDR_W - PAGE_SHIFT;

    logic [ADDR_W-1:0] offset;
    logic [PN_W-1:0]   page_num;
    logic              above_base;
    logic              managed;
    logic              aligned;

    assign above_base = (addr >= BASE_ADDRESS);
    assign offset     = addr - BASE_ADDRESS;
    assign page_num   = offset[ADDR_W-1:PAGE_SHIFT];
    assign managed    = above_base && ({1'b0, page_num} < (PN_W+1)'(NUM_PAGES));
    assign aligned    = (addr[PAGE_SHIFT-1:0] == '0);
    assign idx        = page_num[IDX_W-1:0];

    assign chk.in_range = managed;
    assign chk.free_ok  = managed && aligned && (addr >= kernel_end) && (addr < top_addr);

endmodule

// ----- tb/sv/tb.sv -----
// tb: self-checking bench for refcounted_page_allocator, free list, counts and address checks
// depends on rcpa_pkg and the allocator rtl; keeps its own copy of stack, counts and registers
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rcpa_pkg::*;

    // geometry of the instance under test (package defaults)
    localparam int unsigned     PAGES      = DEF_NUM_PAGES;
    localparam logic [31:0]     BASE       = DEF_BASE_ADDRESS;
    localparam int unsigned     PAGE_BYTES = 1 << PAGE_SHIFT;
    localparam longint unsigned MEM_END    = 64'(BASE) + 64'(PAGES) * PAGE_BYTES;
    localparam logic [DEF_COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // operation codes the block leaves unused
    localparam logic [2:0] OP_SPARE_A = 3'd5;
    localparam logic [2:0] OP_SPARE_B = 3'd6;
    localparam logic [2:0] OP_SPARE_C = 3'd7;

    // run pacing
    localparam int WATCHDOG_LIMIT = 100000;  // covers the clearing pass after reset
    localparam int HOLD_CYCLES    = 300;     // long receiver hold-off
    localparam int SETTLE_CYCLES  = 8;       // settle time after the last result is back

    // one result word as the block reports it
    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] count;
        status_t     st;
    } word_result_t;

    localparam word_result_t NO_FIXED = '{32'h0, 16'h0, ST_OK};

    // directed stimulus row; fixed rows carry an expectation typed in by hand
    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] addr;
        logic        fixed;
        logic [31:0] want_addr;
        logic [15:0] want_count;
        logic [2:0]  want_st;
    } probe_t;

    localparam int N_PROBES = 26;
    localparam probe_t PROBES [N_PROBES] = '{
        // empty stack right after reset
        '{OP_ALLOC,   32'h0000_0000, 1'b1, 32'h0, 16'd0, ST_OOM},
        // count table cleared, low offset bits ignored, range edges
        '{OP_QUERY,   32'h8000_0000, 1'b1, 32'h0, 16'd0, ST_OK},
        '{OP_QUERY,   32'h7FFF_FFFF, 1'b1, 32'h0, 16'd0, ST_BAD},
        '{OP_QUERY,   32'h8800_0000, 1'b1, 32'h0, 16'd0, ST_BAD},
        '{OP_ADDREF,  32'hFFFF_FFFF, 1'b1, 32'h0, 16'd0, ST_BAD},
        '{OP_QUERY,   32'h87FF_FFFF, 1'b1, 32'h0, 16'd0, ST_OK},
        // freeing a page that is already free, unaligned, below base, at top
        '{OP_FREE,    32'h8000_0000, 1'b1, 32'h0, 16'd0, ST_FREE},
        '{OP_FREE,    32'h8000_0800, 1'b1, 32'h0, 16'd0, ST_BAD},
        '{OP_FREE,    32'h0000_0000, 1'b1, 32'h0, 16'd0, ST_BAD},
        '{OP_DONATE,  32'h8800_0000, 1'b1, 32'h0, 16'd0, ST_BAD},
        // seed first and last page, first one twice so it sits on the stack twice
        '{OP_DONATE,  32'h8000_0000, 1'b1, 32'h0, 16'd0, ST_OK},
        '{OP_DONATE,  32'h87FF_F000, 1'b1, 32'h0, 16'd0, ST_OK},
        '{OP_DONATE,  32'h8000_0000, 1'b1, 32'h0, 16'd0, ST_OK},
        // lifo order, then the duplicate comes back with a live count
        '{OP_ALLOC,   32'hFFFF_FFFF, 1'b1, 32'h8000_0000, 16'd1, ST_OK},
        '{OP_ALLOC,   32'h0000_0000, 1'b1, 32'h87FF_F000, 16'd1, ST_OK},
        '{OP_ALLOC,   32'h0000_0000, 1'b1, 32'h8000_0000, 16'd1, ST_DIRTY},
        // shared pages: raise, then walk the count back down and push
        '{OP_ADDREF,  32'h8000_0FFF, 1'b0, 32'h0, 16'd0, ST_OK},
        '{OP_ADDREF,  32'h87FF_F000, 1'b0, 32'h0, 16'd0, ST_OK},
        '{OP_FREE,    32'h8000_0000, 1'b0, 32'h0, 16'd0, ST_OK},
        '{OP_FREE,    32'h8000_0000, 1'b0, 32'h0, 16'd0, ST_OK},
        '{OP_FREE,    32'h8000_0000, 1'b1, 32'h0, 16'd0, ST_FREE},
        // unused codes give an all-zero word, then the stack is emptied again
        '{OP_SPARE_A, 32'hFFFF_FFFF, 1'b1, 32'h0, 16'd0, ST_OK},
        '{OP_SPARE_B, 32'h8000_1000, 1'b1, 32'h0, 16'd0, ST_OK},
        '{OP_SPARE_C, 32'h8000_0000, 1'b1, 32'h0, 16'd0, ST_OK},
        '{OP_ALLOC,   32'h0000_0000, 1'b0, 32'h0, 16'd0, ST_OK},
        '{OP_ALLOC,   32'h0000_0000, 1'b1, 32'h0, 16'd0, ST_OOM}
    };

    // register settings for the random phases: wide, narrow, unaligned, inverted, wide
    localparam int N_PHASES = 5;
    localparam logic [31:0] PHASE_KEND [N_PHASES] =
        '{32'h8000_0000, 32'h8400_0000, 32'h8000_1800, 32'h8800_0000, 32'h8000_0000};
    localparam logic [31:0] PHASE_TOP [N_PHASES] =
        '{32'h8800_0000, 32'h8404_0000, 32'h87FF_F800, 32'h8000_0000, 32'h8800_0000};
    localparam int PHASE_WORDS [N_PHASES] = '{500, 400, 350, 150, 250};

    // clock, reset and block inputs, all known from time zero
    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_write    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_KERNEL_END;
    logic [31:0] cfg_data     = 32'h0;
    logic        in_valid     = 1'b0;
    logic [2:0]  operation    = OP_ALLOC;
    logic [31:0] page_address = 32'h0;
    logic        out_stall    = 1'b0;

    logic        in_stall;
    logic        out_valid;
    logic [31:0] result_address;
    logic [15:0] ref_count;
    logic [2:0]  status;

    // predicted allocator state
    logic [14:0]                free_pages [PAGES];
    int unsigned                free_depth = 0;
    logic [DEF_COUNT_WIDTH-1:0] page_counts [PAGES];
    logic [31:0]                kernel_end = KERNEL_END_RESET;
    logic [31:0]                top_addr   = TOP_ADDR_RESET;

    // expected result words in order, and pages the stimulus believes it holds
    word_result_t due_results [$];
    logic [31:0]  held_pages [$];
    word_result_t head_want;

    // pacing controls shared between sender and receiver
    bit idle_off = 1'b0;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int rx_gap = 0;
    int rx_calm = 0;
    int rx_sel = 0;
    int tx_calm = 0;

    int mismatches = 0;
    int words_in = 0;
    int words_out = 0;
    int stuck_cycles = 0;
    int status_seen [8];

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    refcounted_page_allocator dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .page_address   (page_address),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_address (result_address),
        .ref_count      (ref_count),
        .status         (status)
    );

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // page slot for any address inside managed memory, offset bits ignored
    function automatic bit managed_slot(logic [31:0] addr, output int unsigned slot);
        slot = 0;
        if (addr < BASE)
            return 1'b0;
        slot = (addr - BASE) >> PAGE_SHIFT;
        return slot < PAGES;
    endfunction

    // free and donate also need alignment and the kernel_end..top window
    function automatic bit freeable_slot(logic [31:0] addr, output int unsigned slot);
        slot = 0;
        if (addr[PAGE_SHIFT-1:0] != '0)
            return 1'b0;
        if (addr < kernel_end || addr >= top_addr)
            return 1'b0;
        return managed_slot(addr, slot);
    endfunction

    // outcome of one word, updating the predicted stack and counts
    function automatic word_result_t page_op_outcome(logic [2:0] op, logic [31:0] addr);
        word_result_t r;
        int unsigned slot;
        r = NO_FIXED;
        case (op)
            OP_ALLOC:
            begin
                if (free_depth == 0)
                    r.st = ST_OOM;
                else
                begin
                    free_depth--;
                    slot = free_pages[free_depth];
                    // a page stacked twice or raised while free comes back dirty
                    if (page_counts[slot] != 0)
                        r.st = ST_DIRTY;
                    page_counts[slot] = 1;
                    r.count = 16'd1;
                    r.addr = BASE + (slot << PAGE_SHIFT);
                end
            end
            OP_FREE, OP_DONATE:
            begin
                if (!freeable_slot(addr, slot))
                    r.st = ST_BAD;
                else
                begin
                    if (op == OP_DONATE)
                        page_counts[slot] = 1;
                    if (page_counts[slot] == 0)
                        r.st = ST_FREE;
                    else if (page_counts[slot] == 1)
                    begin
                        // a full stack drops the push but the count still clears
                        if (free_depth < PAGES)
                        begin
                            free_pages[free_depth] = 15'(slot);
                            free_depth++;
                        end
                        page_counts[slot] = 0;
                    end
                    else
                        page_counts[slot]--;
                    r.count = 16'(page_counts[slot]);
                end
            end
            OP_QUERY, OP_ADDREF:
            begin
                if (!managed_slot(addr, slot))
                    r.st = ST_BAD;
                else
                begin
                    if (op == OP_ADDREF && page_counts[slot] != COUNT_MAX)
                        page_counts[slot]++;
                    r.count = 16'(page_counts[slot]);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    // page starts that free and donate accept under the current registers
    function automatic void freeable_window(output longint unsigned lo,
                                            output longint unsigned hi);
        lo = (64'(kernel_end) + PAGE_BYTES - 1) / PAGE_BYTES * PAGE_BYTES;
        if (lo < 64'(BASE))
            lo = 64'(BASE);
        hi = 64'(top_addr);
        if (hi > MEM_END)
            hi = MEM_END;
    endfunction

    // small pool near both ends of the window so pages get reused often
    function automatic logic [31:0] pool_page();
        longint unsigned lo, hi, span, k;
        freeable_window(lo, hi);
        if (lo >= hi)
            return BASE + ($urandom_range(0, PAGES - 1) << PAGE_SHIFT);
        span = (hi - lo + PAGE_BYTES - 1) / PAGE_BYTES;
        k = $urandom_range(0, (span > 32) ? 31 : 32'(span - 1));
        if ($urandom_range(0, 3) == 0)
            return 32'(lo + (span - 1 - k) * PAGE_BYTES);
        return 32'(lo + k * PAGE_BYTES);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= 100)
            $display("[%0t] mismatch on %s at result %0d: want %h got %h",
                     $realtime, what, words_out, want, got);
    endtask

    // only called while no words are in flight
    task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_KERNEL_END: kernel_end = value;
            REG_TOP_ADDR:   top_addr = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // offer one word, wait for the handshake, queue its expected result
    task automatic offer_word(logic [2:0] op, logic [31:0] addr, bit fixed,
                              word_result_t fixed_val, output word_result_t outcome);
        @(negedge clk);
        in_valid     <= 1'b1;
        operation    <= op;
        page_address <= addr;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        words_in++;
        outcome = page_op_outcome(op, addr);
        due_results.push_back(fixed ? fixed_val : outcome);
        // random sender gaps, with calm stretches in between
        if (!idle_off)
        begin
            if (tx_calm > 0)
                tx_calm--;
            else if ($urandom_range(0, 60) == 0)
                tx_calm = $urandom_range(20, 80);
            else if ($urandom_range(0, 4) == 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge clk);
            end
        end
    endtask

    // stop offering until every expected word is back, then let the block settle
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // mostly well-formed traffic on a small page pool, the rest noise
    task automatic run_random(int phase, int count);
        logic [2:0]      op;
        logic [31:0]     addr;
        word_result_t    outcome;
        longint unsigned lo, hi;
        int              sel;
        int              k;
        for (int n = 0; n < count; n++)
        begin
            // receiver hold-off while the sender keeps offering
            if (phase == 0 && n == 200)
                hold_req = 1'b1;
            // sender pause until everything is back
            if (phase == 1 && n == count / 2)
                drain();
            sel = $urandom_range(0, 99);
            addr = $urandom;
            if (sel < 24)
                op = OP_ALLOC;
            else if (sel < 46)
            begin
                op = OP_FREE;
                if (held_pages.size() != 0 && $urandom_range(0, 3) != 0)
                begin
                    k = $urandom_range(0, held_pages.size() - 1);
                    addr = held_pages[k];
                    held_pages.delete(k);
                end
                else
                    addr = pool_page();
            end
            else if (sel < 60)
            begin
                op = OP_DONATE;
                addr = pool_page();
            end
            else if (sel < 70)
            begin
                op = OP_QUERY;
                addr = pool_page() | (addr & 32'hFFF);
            end
            else if (sel < 82)
            begin
                op = OP_ADDREF;
                addr = pool_page() | (addr & 32'hFFF);
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: op = 3'($urandom_range(OP_SPARE_A, OP_SPARE_C));
                    1:
                    begin
                        // misaligned free or donate on an otherwise good page
                        op = ($urandom_range(0, 1) != 0) ? OP_FREE : OP_DONATE;
                        addr = pool_page() | $urandom_range(1, 32'hFFF);
                    end
                    2: op = 3'($urandom_range(OP_ALLOC, OP_DONATE));
                    default:
                    begin
                        // just outside the window, or anywhere in managed memory
                        case ($urandom_range(0, 2))
                            0: op = OP_FREE;
                            1: op = OP_DONATE;
                            default: op = OP_QUERY;
                        endcase
                        freeable_window(lo, hi);
                        case ($urandom_range(0, 2))
                            0: addr = 32'(lo - PAGE_BYTES);
                            1: addr = 32'(hi);
                            default: addr = BASE + ($urandom_range(0, PAGES - 1) << PAGE_SHIFT);
                        endcase
                    end
                endcase
            end
            offer_word(op, addr, 1'b0, NO_FIXED, outcome);
            if (op == OP_ALLOC && outcome.st != ST_OOM)
                held_pages.push_back(outcome.addr);
        end
    endtask

    // ---------------------------------------------------------------
    // result side
    // ---------------------------------------------------------------

    // receiver stall: the long hold-off wins, then no stall in the last phase, else random bursts
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (idle_off)
                out_stall <= 1'b0;
            else if (rx_gap > 0)
            begin
                rx_gap--;
                out_stall <= 1'b1;
            end
            else if (rx_calm > 0)
            begin
                rx_calm--;
                out_stall <= 1'b0;
            end
            else
            begin
                rx_sel = $urandom_range(0, 29);
                if (rx_sel == 0)
                begin
                    rx_calm = $urandom_range(30, 120);
                    out_stall <= 1'b0;
                end
                else if (rx_sel < 5)
                begin
                    rx_gap = $urandom_range(0, 6);
                    out_stall <= 1'b1;
                end
                else
                    out_stall <= 1'b0;
            end
        end
    end

    // each accepted result word against the oldest expectation, field by field
    always @(posedge clk)
    begin
        if (out_valid === 1'b1 && !out_stall)
        begin
            words_out++;
            if (due_results.size() == 0)
                report_mismatch("word with nothing pending", 32'h0, result_address);
            else
            begin
                head_want = due_results.pop_front();
                if (result_address !== head_want.addr)
                    report_mismatch("result_address", head_want.addr, result_address);
                if (ref_count !== head_want.count)
                    report_mismatch("ref_count", 32'(head_want.count), 32'(ref_count));
                if (status !== head_want.st)
                    report_mismatch("status", 32'(head_want.st), 32'(status));
                status_seen[head_want.st]++;
            end
        end
    end

    // cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles == WATCHDOG_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles, %0d results pending",
                     WATCHDOG_LIMIT, due_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial
    begin
        probe_t       row;
        word_result_t outcome;
        foreach (page_counts[i])
            page_counts[i] = '0;
        foreach (free_pages[i])
            free_pages[i] = '0;
        foreach (status_seen[i])
            status_seen[i] = 0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // registers back to their reset values; the clearing pass holds off input
        write_reg(REG_KERNEL_END, KERNEL_END_RESET);
        write_reg(REG_TOP_ADDR, TOP_ADDR_RESET);

        // directed table
        for (int i = 0; i < N_PROBES; i++)
        begin
            row = PROBES[i];
            offer_word(row.op, row.addr, row.fixed,
                       '{row.want_addr, row.want_count, status_t'(row.want_st)}, outcome);
        end
        drain();

        // random phases, one register setting each; no idling in the last part
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            if (ph == N_PHASES - 1)
                idle_off = 1'b1;
            write_reg(REG_KERNEL_END, PHASE_KEND[ph]);
            write_reg(REG_TOP_ADDR, PHASE_TOP[ph]);
            run_random(ph, PHASE_WORDS[ph]);
            drain();
        end

        $display("ran %0d words through %0d register settings, %0d results checked",
                 words_in, N_PHASES + 1, words_out);
        $display("status mix: ok %0d, no memory %0d, bad address %0d, already free %0d, dirty %0d",
                 status_seen[ST_OK], status_seen[ST_OOM], status_seen[ST_BAD],
                 status_seen[ST_FREE], status_seen[ST_DIRTY]);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
